// ===== rtl/ppft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the step table of the pressure force and torque integrator.
// Used by ppft_front, ppft_fifo, ppft_back and the top level; depends on nothing.
package ppft_pkg;

  // Field and datapath widths.
  localparam int NORM_W    = 16;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int GM_W      = 33;   // centroid minus cog
  localparam int PA_W      = 64;   // pressure times area
  localparam int CROSS_W   = 49;   // cross product component
  localparam int HALF_W    = 32;   // split point of the wide operands
  localparam int OPND_W    = 33;   // multiplier operand
  localparam int MUL_W     = 66;   // multiplier product
  localparam int PROD_W    = 113;  // exact wide product
  localparam int OUT_W     = 64;
  localparam int LANES     = 3;
  localparam int LANE_W    = 2;

  // Sequencer.
  localparam int NUM_OPS      = 24;
  localparam int PIPE_LAT     = 3;
  localparam int STEP_W       = 5;
  localparam int FORCE_SHIFT  = 6;
  localparam int TORQUE_SHIFT = 22;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COG_X = 2'd0,
    REG_COG_Y = 2'd1,
    REG_COG_Z = 2'd2
  } reg_idx_t;

  // First multiplier operand source.
  typedef enum logic [1:0] {
    A_GM    = 2'd0,
    A_PA_LO = 2'd1,
    A_PA_HI = 2'd2
  } a_src_t;

  // Second multiplier operand source.
  typedef enum logic [1:0] {
    B_NORM  = 2'd0,
    B_CR_LO = 2'd1,
    B_CR_HI = 2'd2
  } b_src_t;

  // Bit position of a partial product in the wide product.
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } place_t;

  // Where a finished wide product goes.
  typedef enum logic [1:0] {
    DEST_CROSS  = 2'd0,
    DEST_FORCE  = 2'd1,
    DEST_TORQUE = 2'd2
  } dest_t;

  // One multiplier step.
  typedef struct packed {
    a_src_t              a_src;
    logic [LANE_W-1:0]   a_idx;
    b_src_t              b_src;
    logic [LANE_W-1:0]   b_idx;
    place_t              place;
    logic                first;
    logic                fin;
    logic                neg;
    dest_t               dest;
    logic [LANE_W-1:0]   lane;
  } op_t;

  // One classified face as held in the queue.
  typedef struct packed {
    logic [LANES-1:0][NORM_W-1:0] normal;
    logic [LANES-1:0][GM_W-1:0]   gm;
    logic [PA_W-1:0]              pa_raw;  // pressure * area, not yet negated
    logic                         last;
  } face_t;

  function automatic op_t mk_op(a_src_t a_src, logic [LANE_W-1:0] a_idx, b_src_t b_src,
                                logic [LANE_W-1:0] b_idx, place_t place, logic first,
                                logic fin, logic neg, dest_t dest, logic [LANE_W-1:0] lane);
    op_t o;
    o.a_src = a_src;
    o.a_idx = a_idx;
    o.b_src = b_src;
    o.b_idx = b_idx;
    o.place = place;
    o.first = first;
    o.fin   = fin;
    o.neg   = neg;
    o.dest  = dest;
    o.lane  = lane;
    return o;
  endfunction

  // Step table: three cross components from six partials, six force partials, twelve torque partials.
  // The pressure-area factor enters negated, so every step that uses it subtracts.
  function automatic op_t op_at(logic [STEP_W-1:0] step);
    op_t o;
    unique case (step)
      0:  o = mk_op(A_GM, 2'd1, B_NORM, 2'd2, SH_0, 1'b1, 1'b0, 1'b0, DEST_CROSS, 2'd0);
      1:  o = mk_op(A_GM, 2'd2, B_NORM, 2'd1, SH_0, 1'b0, 1'b1, 1'b1, DEST_CROSS, 2'd0);
      2:  o = mk_op(A_GM, 2'd2, B_NORM, 2'd0, SH_0, 1'b1, 1'b0, 1'b0, DEST_CROSS, 2'd1);
      3:  o = mk_op(A_GM, 2'd0, B_NORM, 2'd2, SH_0, 1'b0, 1'b1, 1'b1, DEST_CROSS, 2'd1);
      4:  o = mk_op(A_GM, 2'd0, B_NORM, 2'd1, SH_0, 1'b1, 1'b0, 1'b0, DEST_CROSS, 2'd2);
      5:  o = mk_op(A_GM, 2'd1, B_NORM, 2'd0, SH_0, 1'b0, 1'b1, 1'b1, DEST_CROSS, 2'd2);
      6:  o = mk_op(A_PA_LO, 2'd0, B_NORM, 2'd0, SH_0,  1'b1, 1'b0, 1'b1, DEST_FORCE, 2'd0);
      7:  o = mk_op(A_PA_HI, 2'd0, B_NORM, 2'd0, SH_32, 1'b0, 1'b1, 1'b1, DEST_FORCE, 2'd0);
      8:  o = mk_op(A_PA_LO, 2'd0, B_NORM, 2'd1, SH_0,  1'b1, 1'b0, 1'b1, DEST_FORCE, 2'd1);
      9:  o = mk_op(A_PA_HI, 2'd0, B_NORM, 2'd1, SH_32, 1'b0, 1'b1, 1'b1, DEST_FORCE, 2'd1);
      10: o = mk_op(A_PA_LO, 2'd0, B_NORM, 2'd2, SH_0,  1'b1, 1'b0, 1'b1, DEST_FORCE, 2'd2);
      11: o = mk_op(A_PA_HI, 2'd0, B_NORM, 2'd2, SH_32, 1'b0, 1'b1, 1'b1, DEST_FORCE, 2'd2);
      12: o = mk_op(A_PA_LO, 2'd0, B_CR_LO, 2'd0, SH_0,  1'b1, 1'b0, 1'b1, DEST_TORQUE, 2'd0);
      13: o = mk_op(A_PA_LO, 2'd0, B_CR_HI, 2'd0, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd0);
      14: o = mk_op(A_PA_HI, 2'd0, B_CR_LO, 2'd0, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd0);
      15: o = mk_op(A_PA_HI, 2'd0, B_CR_HI, 2'd0, SH_64, 1'b0, 1'b1, 1'b1, DEST_TORQUE, 2'd0);
      16: o = mk_op(A_PA_LO, 2'd0, B_CR_LO, 2'd1, SH_0,  1'b1, 1'b0, 1'b1, DEST_TORQUE, 2'd1);
      17: o = mk_op(A_PA_LO, 2'd0, B_CR_HI, 2'd1, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd1);
      18: o = mk_op(A_PA_HI, 2'd0, B_CR_LO, 2'd1, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd1);
      19: o = mk_op(A_PA_HI, 2'd0, B_CR_HI, 2'd1, SH_64, 1'b0, 1'b1, 1'b1, DEST_TORQUE, 2'd1);
      20: o = mk_op(A_PA_LO, 2'd0, B_CR_LO, 2'd2, SH_0,  1'b1, 1'b0, 1'b1, DEST_TORQUE, 2'd2);
      21: o = mk_op(A_PA_LO, 2'd0, B_CR_HI, 2'd2, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd2);
      22: o = mk_op(A_PA_HI, 2'd0, B_CR_LO, 2'd2, SH_32, 1'b0, 1'b0, 1'b1, DEST_TORQUE, 2'd2);
      23: o = mk_op(A_PA_HI, 2'd0, B_CR_HI, 2'd2, SH_64, 1'b0, 1'b1, 1'b1, DEST_TORQUE, 2'd2);
      default: o = mk_op(A_GM, 2'd0, B_NORM, 2'd0, SH_0, 1'b0, 1'b0, 1'b0, DEST_CROSS, 2'd0);
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/ppft_front.sv =====
`timescale 1ns / 1ps
// Front part: centre of gravity registers and the classification of each incoming face.
// Forms centroid minus cog and pressure times area; depends on ppft_pkg.
module ppft_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [ppft_pkg::CFG_W-1:0]   cfg_data,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_x,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_y,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_z,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_x,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_y,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_z,
  input  logic signed [ppft_pkg::COORD_W-1:0] pressure,
  input  logic [ppft_pkg::COORD_W-1:0]        area,
  input  logic                                last_face,
  output ppft_pkg::face_t                     face
);

  logic signed [ppft_pkg::COORD_W-1:0] cog_x;
  logic signed [ppft_pkg::COORD_W-1:0] cog_y;
  logic signed [ppft_pkg::COORD_W-1:0] cog_z;
  logic signed [ppft_pkg::COORD_W:0]   area_s;
  logic signed [ppft_pkg::PA_W:0]      pa_full;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cog_x <= '0;
      cog_y <= '0;
      cog_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppft_pkg::REG_COG_X: cog_x <= cfg_data;
        ppft_pkg::REG_COG_Y: cog_y <= cfg_data;
        ppft_pkg::REG_COG_Z: cog_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pressure times area is exact in 64 signed bits; the queue register follows it.
  assign area_s  = $signed({1'b0, area});
  assign pa_full = pressure * area_s;

  // Lever arm and the fields the back part needs.
  always_comb begin
    face.normal[0] = normal_x;
    face.normal[1] = normal_y;
    face.normal[2] = normal_z;
    face.gm[0]     = ppft_pkg::GM_W'(centroid_x) - ppft_pkg::GM_W'(cog_x);
    face.gm[1]     = ppft_pkg::GM_W'(centroid_y) - ppft_pkg::GM_W'(cog_y);
    face.gm[2]     = ppft_pkg::GM_W'(centroid_z) - ppft_pkg::GM_W'(cog_z);
    face.pa_raw    = pa_full[ppft_pkg::PA_W-1:0];
    face.last      = last_face;
  end

endmodule

// ===== rtl/ppft_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of classified faces between the front and the back part.
// Register based, first word shown combinationally on the read side; depends on ppft_pkg.
module ppft_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppft_pkg::face_t wdata,
  output logic            full,
  input  logic            pop,
  output ppft_pkg::face_t rdata,
  output logic            empty
);

  localparam int DEPTH = ppft_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppft_pkg::face_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ppft_back.sv =====
`timescale 1ns / 1ps
// Back part: step sequencer over one shared 33x33 multiplier, wide product accumulator,
// term saturation, saturating sums and the result register; depends on ppft_pkg.
module ppft_back #(
  parameter int ACCUM_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ppft_pkg::face_t                   head,
  input  logic                              head_valid,
  output logic                              head_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [ppft_pkg::OUT_W-1:0] force_x,
  output logic signed [ppft_pkg::OUT_W-1:0] force_y,
  output logic signed [ppft_pkg::OUT_W-1:0] force_z,
  output logic signed [ppft_pkg::OUT_W-1:0] torque_x,
  output logic signed [ppft_pkg::OUT_W-1:0] torque_y,
  output logic signed [ppft_pkg::OUT_W-1:0] torque_z
);

  localparam int STEP_W  = ppft_pkg::STEP_W;
  localparam int PROD_W  = ppft_pkg::PROD_W;
  localparam int OPND_W  = ppft_pkg::OPND_W;
  localparam int MUL_W   = ppft_pkg::MUL_W;
  localparam int CROSS_W = ppft_pkg::CROSS_W;
  localparam int HALF_W  = ppft_pkg::HALF_W;
  localparam int PA_W    = ppft_pkg::PA_W;
  localparam int LANES   = ppft_pkg::LANES;
  localparam int LANE_W  = ppft_pkg::LANE_W;
  localparam int HI_W    = PROD_W - ACCUM_BITS + 1;
  localparam logic [STEP_W-1:0] LAST_ISSUE  = STEP_W'(ppft_pkg::NUM_OPS);
  localparam logic [STEP_W-1:0] FINISH_STEP = STEP_W'(ppft_pkg::NUM_OPS + ppft_pkg::PIPE_LAT);
  localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

  logic [STEP_W-1:0]              step;
  ppft_pkg::op_t                  op;
  logic                           issue;
  logic signed [OPND_W-1:0]       a_op;
  logic signed [OPND_W-1:0]       b_op;
  logic [CROSS_W-1:0]             cr [LANES];

  logic                           s1_valid;
  ppft_pkg::op_t                  s1_op;
  logic signed [MUL_W-1:0]        m_prod;

  logic [PROD_W-1:0]              ext;
  logic [PROD_W-1:0]              placed;
  logic [PROD_W-1:0]              addend;
  logic [PROD_W-1:0]              base;
  logic [PROD_W-1:0]              prod_next;
  logic                           s2_valid;
  ppft_pkg::op_t                  s2_op;
  logic [PROD_W-1:0]              prod;

  logic signed [PROD_W-1:0]       shifted;
  logic [HI_W-1:0]                hi_bits;
  logic signed [ACCUM_BITS-1:0]   term_next;
  logic                           s3_valid;
  ppft_pkg::dest_t                s3_dest;
  logic [LANE_W-1:0]              s3_lane;
  logic signed [ACCUM_BITS-1:0]   term;

  logic signed [ACCUM_BITS-1:0]   force_sum [LANES];
  logic signed [ACCUM_BITS-1:0]   torque_sum [LANES];
  logic signed [ACCUM_BITS-1:0]   cur;
  logic signed [ACCUM_BITS:0]     sum_wide;
  logic signed [ACCUM_BITS-1:0]   sum_sat;

  logic                           res_valid;
  logic                           at_finish;
  logic                           done;
  logic                           emit;

  // Step decode and issue.
  assign op    = ppft_pkg::op_at(step);
  assign issue = head_valid && (step < LAST_ISSUE);

  // Operand selection: wide values are split into an unsigned low and a signed high half.
  always_comb begin
    unique case (op.a_src)
      ppft_pkg::A_GM:    a_op = head.gm[op.a_idx];
      ppft_pkg::A_PA_LO: a_op = {1'b0, head.pa_raw[HALF_W-1:0]};
      ppft_pkg::A_PA_HI: a_op = OPND_W'($signed(head.pa_raw[PA_W-1:HALF_W]));
      default:           a_op = '0;
    endcase
    unique case (op.b_src)
      ppft_pkg::B_NORM:  b_op = OPND_W'($signed(head.normal[op.b_idx]));
      ppft_pkg::B_CR_LO: b_op = {1'b0, cr[op.b_idx][HALF_W-1:0]};
      ppft_pkg::B_CR_HI: b_op = OPND_W'($signed(cr[op.b_idx][CROSS_W-1:HALF_W]));
      default:           b_op = '0;
    endcase
  end

  // Multiplier stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_op  <= op;
      m_prod <= a_op * b_op;
    end
  end

  // Accumulate a placed, possibly negated partial product into the wide product.
  always_comb begin
    ext = PROD_W'(m_prod);
    unique case (s1_op.place)
      ppft_pkg::SH_0:  placed = ext;
      ppft_pkg::SH_32: placed = ext << 32;
      ppft_pkg::SH_64: placed = ext << 64;
      default:         placed = '0;
    endcase
    addend    = s1_op.neg ? ~placed : placed;
    base      = s1_op.first ? '0 : prod;
    prod_next = base + addend + PROD_W'(s1_op.neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_op <= s1_op;
      prod  <= prod_next;
    end
  end

  // Finished product: a cross component is kept, a force or torque term is scaled
  // by an arithmetic shift and clamped to the accumulator range.
  always_comb begin
    if (s2_op.dest == ppft_pkg::DEST_FORCE) begin
      shifted = $signed(prod) >>> ppft_pkg::FORCE_SHIFT;
    end else begin
      shifted = $signed(prod) >>> ppft_pkg::TORQUE_SHIFT;
    end
    hi_bits = shifted[PROD_W-1:ACCUM_BITS-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      term_next = shifted[ACCUM_BITS-1:0];
    end else begin
      term_next = prod[PROD_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && s2_op.fin && (s2_op.dest != ppft_pkg::DEST_CROSS);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_op.fin) begin
      if (s2_op.dest == ppft_pkg::DEST_CROSS) begin
        cr[s2_op.lane] <= prod[CROSS_W-1:0];
      end else begin
        term    <= term_next;
        s3_dest <= s2_op.dest;
        s3_lane <= s2_op.lane;
      end
    end
  end

  // Saturating add of the term into its sum.
  always_comb begin
    cur = (s3_dest == ppft_pkg::DEST_FORCE) ? force_sum[s3_lane] : torque_sum[s3_lane];
    sum_wide = (ACCUM_BITS+1)'(cur) + (ACCUM_BITS+1)'(term);
    if (sum_wide[ACCUM_BITS] != sum_wide[ACCUM_BITS-1]) begin
      sum_sat = sum_wide[ACCUM_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACCUM_BITS-1:0];
    end
  end

  // End of a face: the last face of a mesh waits for room in the result register.
  assign at_finish = head_valid && (step == FINISH_STEP);
  assign done      = at_finish && (!head.last || !res_valid || pop);
  assign emit      = done && head.last;
  assign head_pop  = done;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (done) begin
      step <= '0;
    end else if (head_valid && (step != FINISH_STEP)) begin
      step <= step + 1'b1;
    end
  end

  // Sums: cleared on reset and after each emitted result.
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      for (int i = 0; i < LANES; i++) begin
        force_sum[i]  <= '0;
        torque_sum[i] <= '0;
      end
    end else if (s3_valid) begin
      if (s3_dest == ppft_pkg::DEST_FORCE) begin
        force_sum[s3_lane] <= sum_sat;
      end else begin
        torque_sum[s3_lane] <= sum_sat;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      force_x  <= ppft_pkg::OUT_W'(force_sum[0]);
      force_y  <= ppft_pkg::OUT_W'(force_sum[1]);
      force_z  <= ppft_pkg::OUT_W'(force_sum[2]);
      torque_x <= ppft_pkg::OUT_W'(torque_sum[0]);
      torque_y <= ppft_pkg::OUT_W'(torque_sum[1]);
      torque_z <= ppft_pkg::OUT_W'(torque_sum[2]);
    end
  end

  // The pipeline has drained by the time a face is finished.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (step == FINISH_STEP) |-> (!s1_valid && !s2_valid && !s3_valid))
    else $error("face finished with products still in flight");

  // A torque step never reads a cross component that is still being formed.
  a_cross_ready: assert property (@(posedge clk) disable iff (rst)
    (issue && (op.b_src == ppft_pkg::B_CR_LO || op.b_src == ppft_pkg::B_CR_HI)) |->
    !((s1_valid && s1_op.dest == ppft_pkg::DEST_CROSS) ||
      (s2_valid && s2_op.dest == ppft_pkg::DEST_CROSS)))
    else $error("cross component read before it was written");

  // Emitting a result leaves all sums cleared for the next mesh.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    emit |=> (force_sum[0] == '0 && force_sum[1] == '0 && force_sum[2] == '0 &&
              torque_sum[0] == '0 && torque_sum[1] == '0 && torque_sum[2] == '0))
    else $error("sums not cleared after a result");

endmodule

// ===== rtl/panel_pressure_force_torque.sv =====
`timescale 1ns / 1ps
// Top level of the pressure force and torque integrator over mesh faces.
// Instantiates ppft_front, ppft_fifo and ppft_back; depends on ppft_pkg.
//
//   channel   ports                                   transaction when
//   --------  --------------------------------------  ---------------------------
//   config    cfg_we, cfg_index, cfg_data             cfg_we high
//   face in   push, full, normal_*, centroid_*,       push high and full low
//             pressure, area, last_face
//   result    empty, pop, force_*, torque_*           pop high and empty low
//
// Each face passes in the back part through 24 steps on its single 33x33 multiplier,
// the drain of the multiplier, accumulate and term registers and one finish step.
// The queue holds two classified faces, the one in work included, so the input side
// takes one more face while the back part works; then full stays high until it finishes.
// The last face of a mesh holds in its finish cycle while the result register is full.
// Reset is synchronous and clears the cog registers, the sums, the queue and the result.
module panel_pressure_force_torque #(
  parameter int ACCUM_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [ppft_pkg::CFG_W-1:0]   cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_x,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_y,
  input  logic signed [ppft_pkg::NORM_W-1:0]  normal_z,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_x,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_y,
  input  logic signed [ppft_pkg::COORD_W-1:0] centroid_z,
  input  logic signed [ppft_pkg::COORD_W-1:0] pressure,
  input  logic [ppft_pkg::COORD_W-1:0]        area,
  input  logic                                last_face,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ppft_pkg::OUT_W-1:0]   force_x,
  output logic signed [ppft_pkg::OUT_W-1:0]   force_y,
  output logic signed [ppft_pkg::OUT_W-1:0]   force_z,
  output logic signed [ppft_pkg::OUT_W-1:0]   torque_x,
  output logic signed [ppft_pkg::OUT_W-1:0]   torque_y,
  output logic signed [ppft_pkg::OUT_W-1:0]   torque_z
);

  ppft_pkg::face_t face_in;
  ppft_pkg::face_t head;
  logic            q_empty;
  logic            head_pop;

  // Classification of incoming faces.
  ppft_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .centroid_x (centroid_x),
    .centroid_y (centroid_y),
    .centroid_z (centroid_z),
    .pressure   (pressure),
    .area       (area),
    .last_face  (last_face),
    .face       (face_in)
  );

  // Queue between front and back.
  ppft_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (face_in),
    .full  (full),
    .pop   (head_pop),
    .rdata (head),
    .empty (q_empty)
  );

  // Products, accumulation and results.
  ppft_back #(
    .ACCUM_BITS (ACCUM_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z),
    .torque_x   (torque_x),
    .torque_y   (torque_y),
    .torque_z   (torque_z)
  );

endmodule
